[rtl/dtw_distance_and_warp_path_assert.svh]
// Assertion macros shared by the checker of the warp-path block.
`ifndef DTW_DISTANCE_AND_WARP_PATH_ASSERT_SVH
`define DTW_DISTANCE_AND_WARP_PATH_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define DTW_ASSERT_IMP(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("dtw check failed");

// Next-cycle implication, switched off while reset is high.
`define DTW_ASSERT_NXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("dtw check failed");

// Next-cycle implication that also holds across reset.
`define DTW_ASSERT_NXT_ALL(lbl, clk, a, b) \
   lbl: assert property (@(posedge clk) (a) |=> (b)) \
      else $error("dtw check failed");

`endif

[rtl/dtw_pkg.sv]
// Types and constants of the warp-path block.
package dtw_pkg;

   localparam int LEN_W   = 6;
   localparam int POS_W   = 6;
   localparam int COST_W  = 24;
   localparam int FRAC_W  = 8;
   localparam int NORM_W  = 32;
   localparam int DIV_W   = LEN_W + 1;
   localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

   localparam logic [1:0] KIND_LOAD_A = 2'd0;
   localparam logic [1:0] KIND_LOAD_B = 2'd1;
   localparam logic [1:0] KIND_RUN    = 2'd2;

   localparam logic [1:0] CSR_LEN_A = 2'd0;
   localparam logic [1:0] CSR_LEN_B = 2'd1;

   // Cost memory read address source.
   localparam logic [1:0] RD_FILL = 2'd0;
   localparam logic [1:0] RD_DG   = 2'd1;
   localparam logic [1:0] RD_UP   = 2'd2;
   localparam logic [1:0] RD_LF   = 2'd3;

   typedef struct packed {
      logic [1:0]         kind;
      logic [4:0]         position;
      logic signed [15:0] sample;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]  pos_a;
      logic [POS_W-1:0]  pos_b;
      logic [NORM_W-1:0] norm_distance;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic       run_start;
      logic [1:0] rd_sel;
      logic       cap_dg;
      logic       cap_up;
      logic       bt_init;
      logic       bt_step;
      logic       div_init;
      logic       emit_init;
   } cmd_type;

   typedef struct packed {
      logic fill_busy;
      logic bt_origin;
      logic bt_edge;
      logic div_busy;
      logic emit_busy;
   } status_type;

endpackage

[rtl/dtw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dtw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

[rtl/dtw_ctrl.sv]
// Sequencer of the warp-path block: fill, backtrace, divide and emit phases.
module dtw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          kind,
   input  dtw_pkg::status_type status,
   output dtw_pkg::cmd_type    cmd,
   output logic                busy
);
   import dtw_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FILL   = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_RD_DG  = 3'd3;
   localparam logic [2:0] ST_RD_UP  = 3'd4;
   localparam logic [2:0] ST_RD_LF  = 3'd5;
   localparam logic [2:0] ST_DEC    = 3'd6;
   localparam logic [2:0] ST_DIV    = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       emit_ff, emit_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      emit_in  = emit_ff;
      cmd      = '0;
      cmd.rd_sel = RD_FILL;
      case (state_ff)
         ST_IDLE: begin
            if (accept && kind == KIND_RUN) begin
               cmd.run_start = 1'b1;
               state_in      = ST_FILL;
            end
         end
         ST_FILL: begin
            if (!status.fill_busy) begin
               cmd.bt_init = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.bt_origin) begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end else if (status.bt_edge) begin
               cmd.bt_step = 1'b1;
            end else begin
               state_in = ST_RD_DG;
            end
         end
         ST_RD_DG: begin
            cmd.rd_sel = RD_DG;
            state_in   = ST_RD_UP;
         end
         ST_RD_UP: begin
            cmd.rd_sel = RD_UP;
            cmd.cap_dg = 1'b1;
            state_in   = ST_RD_LF;
         end
         ST_RD_LF: begin
            cmd.rd_sel = RD_LF;
            cmd.cap_up = 1'b1;
            state_in   = ST_DEC;
         end
         ST_DEC: begin
            cmd.bt_step = 1'b1;
            state_in    = ST_CHECK;
         end
         ST_DIV: begin
            // Division first, then the emission of the stored path.
            if (!emit_ff) begin
               if (!status.div_busy) begin
                  cmd.emit_init = 1'b1;
                  emit_in       = 1'b1;
               end
            end else if (!status.emit_busy) begin
               emit_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         emit_ff  <= emit_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[rtl/dtw_datapath.sv]
// Datapath of the warp-path block: sample stores, cost fill, backtrace,
// divider and path emission.
module dtw_datapath #(
   parameter int MAX_LEN     = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  dtw_pkg::req_type           req_data,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_index,
   input  logic [dtw_pkg::LEN_W-1:0]  csr_wdata,
   input  dtw_pkg::cmd_type           cmd,
   output dtw_pkg::status_type        status,
   output logic                       rsp_strobe,
   output dtw_pkg::rsp_type           rsp_data
);
   import dtw_pkg::*;

   localparam int IDX_W      = $clog2(MAX_LEN);
   localparam int CELLS      = 1 << (2 * IDX_W);
   localparam int CA_W       = 2 * IDX_W;
   localparam int PATH_DEPTH = 2 * MAX_LEN - 1;
   localparam int PA_W       = $clog2(PATH_DEPTH);
   localparam int PD_W       = 2 * IDX_W;
   localparam int D_W        = SAMPLE_BITS + 1;
   localparam int SUM_W      = ((D_W > COST_W) ? D_W : COST_W) + 2;
   localparam int CNT_W      = $clog2(NORM_W + 1);
   localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_LEN);

   // Configuration registers.
   logic [LEN_W-1:0] len_a_ff, len_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_a_ff <= LEN_W'(1);
         len_b_ff <= LEN_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_LEN_A: len_a_ff <= csr_wdata;
            CSR_LEN_B: len_b_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Sample stores, written by load beats.
   logic signed [SAMPLE_BITS-1:0] ser_a_ff [MAX_LEN];
   logic signed [SAMPLE_BITS-1:0] ser_b_ff [MAX_LEN];
   logic                          pos_ok;
   logic signed [SAMPLE_BITS-1:0] sample_w;

   assign pos_ok   = LEN_W'(req_data.position) < MAX_L;
   assign sample_w = SAMPLE_BITS'(req_data.sample);

   always_ff @(posedge clock) begin
      if (accept && pos_ok) begin
         if (req_data.kind == KIND_LOAD_A) begin
            ser_a_ff[req_data.position[IDX_W-1:0]] <= sample_w;
         end
         if (req_data.kind == KIND_LOAD_B) begin
            ser_b_ff[req_data.position[IDX_W-1:0]] <= sample_w;
         end
      end
   end

   // Effective lengths, clamped into one to the maximum.
   logic [LEN_W-1:0] eff_a, eff_b;

   always_comb begin
      eff_a = (len_a_ff == '0) ? LEN_W'(1) : ((len_a_ff > MAX_L) ? MAX_L : len_a_ff);
      eff_b = (len_b_ff == '0) ? LEN_W'(1) : ((len_b_ff > MAX_L) ? MAX_L : len_b_ff);
   end

   // Registers of the run.
   logic [IDX_W-1:0] la_m1_ff, la_m1_in, lb_m1_ff, lb_m1_in;
   logic [DIV_W-1:0] lsum_ff, lsum_in;
   // Fill, first stage: cell counters and local cost.
   logic             f_run_ff, f_run_in;
   logic [IDX_W-1:0] fi_ff, fi_in, fj_ff, fj_in;
   // Fill, second stage: cell update.
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_i0_ff, s1_i0_in, s1_j0_ff, s1_j0_in, s1_last_ff, s1_last_in;
   logic [CA_W-1:0]  s1_addr_ff, s1_addr_in;
   logic [D_W-1:0]   d_ff, d_in;
   logic [COST_W-1:0] left_ff, left_in, diag_ff, diag_in, cost_ff, cost_in;
   // Backtrace.
   logic [IDX_W-1:0] bi_ff, bi_in, bj_ff, bj_in;
   logic [PA_W-1:0]  n_ff, n_in;
   logic [COST_W-1:0] dg_ff, dg_in, up_ff, up_in;
   // Divider.
   logic [NORM_W-1:0] q_ff, q_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dcnt_ff, dcnt_in;
   // Emission.
   logic             e_run_ff, e_run_in, o_valid_ff, o_valid_in, o_last_ff, o_last_in;
   logic [PA_W-1:0]  e_ptr_ff, e_ptr_in;

   // Memories and their ports.
   logic              cost_we;
   logic [CA_W-1:0]   cost_raddr;
   logic [COST_W-1:0] cost_wdata, cost_rdata;
   logic              path_we;
   logic [PA_W-1:0]   path_waddr;
   logic [PD_W-1:0]   path_wdata, path_rdata;

   dtw_ram #(.WIDTH(COST_W), .DEPTH(CELLS)) u_cost_ram (
      .clock (clock),
      .we    (cost_we),
      .waddr (s1_addr_ff),
      .wdata (cost_wdata),
      .raddr (cost_raddr),
      .rdata (cost_rdata)
   );

   dtw_ram #(.WIDTH(PD_W), .DEPTH(PATH_DEPTH)) u_path_ram (
      .clock (clock),
      .we    (path_we),
      .waddr (path_waddr),
      .wdata (path_wdata),
      .raddr (e_ptr_ff),
      .rdata (path_rdata)
   );

   // Cost memory read address by phase.
   always_comb begin
      case (cmd.rd_sel)
         RD_DG:   cost_raddr = {bi_ff - IDX_W'(1), bj_ff - IDX_W'(1)};
         RD_UP:   cost_raddr = {bi_ff - IDX_W'(1), bj_ff};
         RD_LF:   cost_raddr = {bi_ff, bj_ff - IDX_W'(1)};
         default: cost_raddr = {fi_ff - IDX_W'(1), fj_ff};
      endcase
   end

   // Local cost of the cell in the first stage.
   logic signed [D_W-1:0] diff;
   assign diff = D_W'(ser_a_ff[fi_ff]) - D_W'(ser_b_ff[fj_ff]);

   // Cell update: least of the three moves, saturated.
   logic [COST_W-1:0] up_val;
   logic [SUM_W-1:0]  s_up, s_left, s_diag, best;

   always_comb begin
      // With a single column the cell above is the one just computed.
      up_val = (lb_m1_ff == '0) ? left_ff : cost_rdata;
      s_up   = SUM_W'(up_val) + SUM_W'(d_ff);
      s_left = SUM_W'(left_ff) + SUM_W'(d_ff);
      s_diag = SUM_W'(diag_ff) + (SUM_W'(d_ff) << 1);
      if (s1_i0_ff && s1_j0_ff) begin
         best = SUM_W'(d_ff);
      end else if (s1_j0_ff) begin
         best = s_up;
      end else if (s1_i0_ff) begin
         best = s_left;
      end else begin
         best = (s_up < s_left) ? s_up : s_left;
         if (s_diag < best) begin
            best = s_diag;
         end
      end
      cost_wdata = (best > SUM_W'(COST_MAX)) ? COST_MAX : best[COST_W-1:0];
      cost_we    = s1_valid_ff;
   end

   // Backtrace decision on the three neighbours.
   logic [COST_W-1:0] bmin;
   logic [IDX_W-1:0]  nbi, nbj;

   always_comb begin
      bmin = (dg_ff < up_ff) ? dg_ff : up_ff;
      if (cost_rdata < bmin) begin
         bmin = cost_rdata;
      end
      nbi = bi_ff;
      nbj = bj_ff;
      if (bi_ff == '0) begin
         nbj = bj_ff - IDX_W'(1);
      end else if (bj_ff == '0) begin
         nbi = bi_ff - IDX_W'(1);
      end else if (dg_ff == bmin) begin
         nbi = bi_ff - IDX_W'(1);
         nbj = bj_ff - IDX_W'(1);
      end else if (cost_rdata == bmin) begin
         nbj = bj_ff - IDX_W'(1);
      end else begin
         nbi = bi_ff - IDX_W'(1);
      end
   end

   // Divider step: one quotient bit a cycle.
   logic [DIV_W:0] rem_t;
   assign rem_t = {rem_ff, q_ff[NORM_W-1]};

   // Next values of the datapath registers.
   always_comb begin
      la_m1_in    = la_m1_ff;
      lb_m1_in    = lb_m1_ff;
      lsum_in     = lsum_ff;
      f_run_in    = f_run_ff;
      fi_in       = fi_ff;
      fj_in       = fj_ff;
      s1_valid_in = f_run_ff;
      s1_i0_in    = (fi_ff == '0);
      s1_j0_in    = (fj_ff == '0);
      s1_last_in  = (fi_ff == la_m1_ff) && (fj_ff == lb_m1_ff);
      s1_addr_in  = {fi_ff, fj_ff};
      d_in        = diff[D_W-1] ? D_W'(-diff) : D_W'(diff);
      left_in     = left_ff;
      diag_in     = diag_ff;
      cost_in     = cost_ff;
      bi_in       = bi_ff;
      bj_in       = bj_ff;
      n_in        = n_ff;
      dg_in       = cmd.cap_dg ? cost_rdata : dg_ff;
      up_in       = cmd.cap_up ? cost_rdata : up_ff;
      q_in        = q_ff;
      rem_in      = rem_ff;
      dcnt_in     = dcnt_ff;
      e_run_in    = e_run_ff;
      e_ptr_in    = e_ptr_ff;
      o_valid_in  = e_run_ff;
      o_last_in   = (e_ptr_ff == '0);
      path_we     = 1'b0;
      path_waddr  = n_ff;
      path_wdata  = {nbi, nbj};

      if (cmd.run_start) begin
         la_m1_in = IDX_W'(eff_a - LEN_W'(1));
         lb_m1_in = IDX_W'(eff_b - LEN_W'(1));
         lsum_in  = DIV_W'(eff_a) + DIV_W'(eff_b);
         f_run_in = 1'b1;
         fi_in    = '0;
         fj_in    = '0;
      end else if (f_run_ff) begin
         if (fj_ff == lb_m1_ff) begin
            fj_in = '0;
            if (fi_ff == la_m1_ff) begin
               f_run_in = 1'b0;
            end else begin
               fi_in = fi_ff + IDX_W'(1);
            end
         end else begin
            fj_in = fj_ff + IDX_W'(1);
         end
      end

      if (s1_valid_ff) begin
         left_in = cost_wdata;
         diag_in = up_val;
         if (s1_last_ff) begin
            cost_in = cost_wdata;
         end
      end

      if (cmd.bt_init) begin
         bi_in      = la_m1_ff;
         bj_in      = lb_m1_ff;
         path_we    = 1'b1;
         path_waddr = '0;
         path_wdata = {la_m1_ff, lb_m1_ff};
         n_in       = PA_W'(1);
      end else if (cmd.bt_step) begin
         bi_in = nbi;
         bj_in = nbj;
         if (n_ff < PA_W'(PATH_DEPTH)) begin
            path_we = 1'b1;
            n_in    = n_ff + PA_W'(1);
         end
      end

      if (cmd.div_init) begin
         q_in    = {cost_ff, FRAC_W'(0)};
         rem_in  = '0;
         dcnt_in = CNT_W'(NORM_W);
      end else if (dcnt_ff != '0) begin
         dcnt_in = dcnt_ff - CNT_W'(1);
         if (rem_t >= {1'b0, lsum_ff}) begin
            rem_in = DIV_W'(rem_t - {1'b0, lsum_ff});
            q_in   = {q_ff[NORM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_t[DIV_W-1:0];
            q_in   = {q_ff[NORM_W-2:0], 1'b0};
         end
      end

      if (cmd.emit_init) begin
         e_run_in = 1'b1;
         e_ptr_in = n_ff - PA_W'(1);
      end else if (e_run_ff) begin
         if (e_ptr_ff == '0) begin
            e_run_in = 1'b0;
         end else begin
            e_ptr_in = e_ptr_ff - PA_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_run_ff    <= 1'b0;
         s1_valid_ff <= 1'b0;
         dcnt_ff     <= '0;
         e_run_ff    <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         f_run_ff    <= f_run_in;
         s1_valid_ff <= s1_valid_in;
         dcnt_ff     <= dcnt_in;
         e_run_ff    <= e_run_in;
         o_valid_ff  <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      la_m1_ff   <= la_m1_in;
      lb_m1_ff   <= lb_m1_in;
      lsum_ff    <= lsum_in;
      fi_ff      <= fi_in;
      fj_ff      <= fj_in;
      s1_i0_ff   <= s1_i0_in;
      s1_j0_ff   <= s1_j0_in;
      s1_last_ff <= s1_last_in;
      s1_addr_ff <= s1_addr_in;
      d_ff       <= d_in;
      left_ff    <= left_in;
      diag_ff    <= diag_in;
      cost_ff    <= cost_in;
      bi_ff      <= bi_in;
      bj_ff      <= bj_in;
      n_ff       <= n_in;
      dg_ff      <= dg_in;
      up_ff      <= up_in;
      q_ff       <= q_in;
      rem_ff     <= rem_in;
      e_ptr_ff   <= e_ptr_in;
      o_last_ff  <= o_last_in;
   end

   // Status towards the sequencer.
   always_comb begin
      status.fill_busy = f_run_ff || s1_valid_ff;
      status.bt_origin = (bi_ff == '0) && (bj_ff == '0);
      status.bt_edge   = (bi_ff == '0) || (bj_ff == '0);
      status.div_busy  = (dcnt_ff != '0);
      status.emit_busy = e_run_ff || o_valid_ff;
   end

   // Result beat, straight from the path memory read.
   always_comb begin
      rsp_strobe             = o_valid_ff;
      rsp_data.pos_a         = POS_W'(path_rdata[PD_W-1:IDX_W]) + POS_W'(1);
      rsp_data.pos_b         = POS_W'(path_rdata[IDX_W-1:0]) + POS_W'(1);
      rsp_data.norm_distance = o_last_ff ? q_ff : '0;
      rsp_data.last          = o_last_ff;
   end

endmodule

[rtl/dtw_distance_and_warp_path.sv]
// Top level of the dynamic time warping block with warp-path output.
//
//   channel   ports                                  direction
//   request   start, busy, req_data                  in (beat when start && !busy)
//   result    rsp_strobe, rsp_data                   out (one beat per strobe cycle)
//   config    csr_we, csr_index, csr_wdata           in (write on csr_we)
//
// A load beat leaves busy low. A run beat fills the cost matrix one cell a cycle
// on the cost memory port, backtraces by reading the diagonal, upper and left
// neighbour of each inner point, then divides bit-serially and emits one point a cycle.
// Reset is synchronous and active high and sets both lengths to one.
// The receiver cannot stall: each result beat is shown for a single cycle.
module dtw_distance_and_warp_path #(
   parameter int MAX_LEN     = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  dtw_pkg::req_type          req_data,
   output logic                      rsp_strobe,
   output dtw_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [dtw_pkg::LEN_W-1:0] csr_wdata
);
   import dtw_pkg::*;

   logic       accept;
   cmd_type    cmd;
   status_type status;

   assign accept = start && !busy;

   dtw_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .kind   (req_data.kind),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   dtw_datapath #(
      .MAX_LEN     (MAX_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

[rtl/dtw_checker.sv]
// Port-level checks of the warp-path block, bound to the top level.
`include "dtw_distance_and_warp_path_assert.svh"

module dtw_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input dtw_pkg::req_type req_data,
   input logic             rsp_strobe,
   input dtw_pkg::rsp_type rsp_data
);
   import dtw_pkg::*;

   // Result beats only come while a run is in progress.
   `DTW_ASSERT_IMP(a_strobe_busy, clock, reset, rsp_strobe, busy)
   // An accepted run beat makes the block busy.
   `DTW_ASSERT_NXT(a_run_busy, clock, reset, start && !busy && req_data.kind == KIND_RUN, busy)
   // The final point closes the run's beats.
   `DTW_ASSERT_NXT(a_last_ends, clock, reset, rsp_strobe && rsp_data.last, !rsp_strobe)
   // Only the final point carries a distance.
   `DTW_ASSERT_IMP(a_norm_zero, clock, reset, rsp_strobe && !rsp_data.last,
                   rsp_data.norm_distance == '0)
   // Reset leaves the block idle with no beat pending.
   `DTW_ASSERT_NXT_ALL(a_reset_idle, clock, reset, !busy && !rsp_strobe)

endmodule

bind dtw_distance_and_warp_path dtw_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

[tb/tb_dtw_distance_and_warp_path.sv]
// Self-checking testbench of the dynamic time warping block with warp-path output.
`timescale 1ns / 100ps

module tb_dtw_distance_and_warp_path;
   import dtw_pkg::*;

   localparam int MAXN = 32;
   localparam int CYCLE_LIMIT = 2_000_000;

   // Codes that the block has no use for and must ignore.
   localparam logic [1:0] KIND_UNUSED  = 2'd3;
   localparam logic [1:0] CSR_UNUSED_2 = 2'd2;
   localparam logic [1:0] CSR_UNUSED_3 = 2'd3;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_data;
   logic                rsp_strobe;
   rsp_type             rsp_data;
   logic                csr_we;
   logic [1:0]          csr_index;
   logic [LEN_W-1:0]    csr_wdata;

   // Predictor state: lengths as written, the two sample stores and the cost matrix.
   logic [LEN_W-1:0]    pred_len_a, pred_len_b;
   logic signed [15:0]  samples_a [MAXN];
   logic signed [15:0]  samples_b [MAXN];
   logic [COST_W-1:0]   acc_cost [MAXN][MAXN];

   rsp_type             path_expected [$];
   int                  fail_count;
   int                  cycle_count;
   bit                  quiet;

   dtw_distance_and_warp_path dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Free-running clock.
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Cycle limit guards against a hung block.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Each result beat is compared with the oldest predicted path point.
   always @(posedge clock) begin
      rsp_type exp_pt;
      if (!reset && rsp_strobe) begin
         if (path_expected.size() == 0) begin
            $error("unexpected result beat pos_a=%0d pos_b=%0d", rsp_data.pos_a, rsp_data.pos_b);
            fail_count++;
         end else begin
            exp_pt = path_expected.pop_front();
            if (rsp_data.pos_a !== exp_pt.pos_a) begin
               $error("pos_a expected %0d got %0d", exp_pt.pos_a, rsp_data.pos_a);
               fail_count++;
            end
            if (rsp_data.pos_b !== exp_pt.pos_b) begin
               $error("pos_b expected %0d got %0d", exp_pt.pos_b, rsp_data.pos_b);
               fail_count++;
            end
            if (rsp_data.norm_distance !== exp_pt.norm_distance) begin
               $error("norm_distance expected %0d got %0d",
                      exp_pt.norm_distance, rsp_data.norm_distance);
               fail_count++;
            end
            if (rsp_data.last !== exp_pt.last) begin
               $error("last expected %0d got %0d", exp_pt.last, rsp_data.last);
               fail_count++;
            end
         end
      end
   end

   function automatic int effective_len(logic [LEN_W-1:0] r);
      if (r == 0) return 1;
      if (r > MAXN) return MAXN;
      return int'(r);
   endfunction

   // Fills the cost matrix, backtraces and queues the warp path in forward order.
   task automatic predict_warp_path();
      int la, lb, i, j, n, k;
      longint d, best, up, lf, dg;
      logic [COST_W-1:0] m;
      int pa [$], pb [$];
      longint norm;
      rsp_type pt;
      la = effective_len(pred_len_a);
      lb = effective_len(pred_len_b);
      for (i = 0; i < la; i++)
         for (j = 0; j < lb; j++) begin
            d = longint'(samples_a[i]) - longint'(samples_b[j]);
            if (d < 0) d = -d;
            if (i == 0 && j == 0) best = d;
            else if (j == 0) best = longint'(acc_cost[i-1][0]) + d;
            else if (i == 0) best = longint'(acc_cost[0][j-1]) + d;
            else begin
               up = longint'(acc_cost[i-1][j]) + d;
               lf = longint'(acc_cost[i][j-1]) + d;
               dg = longint'(acc_cost[i-1][j-1]) + 2 * d;
               best = up < lf ? up : lf;
               if (dg < best) best = dg;
            end
            acc_cost[i][j] = best > longint'(COST_MAX) ? COST_MAX : best[COST_W-1:0];
         end
      i = la - 1;
      j = lb - 1;
      pa.push_front(i);
      pb.push_front(j);
      while (i > 0 || j > 0) begin
         if (i == 0) j--;
         else if (j == 0) i--;
         else begin
            m = acc_cost[i-1][j-1] < acc_cost[i-1][j] ? acc_cost[i-1][j-1] : acc_cost[i-1][j];
            if (acc_cost[i][j-1] < m) m = acc_cost[i][j-1];
            if (acc_cost[i-1][j-1] == m) begin
               i--;
               j--;
            end else if (acc_cost[i][j-1] == m) j--;
            else i--;
         end
         pa.push_front(i);
         pb.push_front(j);
      end
      n = pa.size();
      norm = (longint'(acc_cost[la-1][lb-1]) << 8) / (la + lb);
      for (k = 0; k < n; k++) begin
         pt.pos_a = POS_W'(pa[k] + 1);
         pt.pos_b = POS_W'(pb[k] + 1);
         pt.last = (k == n - 1);
         pt.norm_distance = pt.last ? norm[NORM_W-1:0] : '0;
         path_expected.insert(path_expected.size(), pt);
      end
   endtask

   // Random gap before a beat, absent in the quiet part of the run.
   task automatic maybe_idle();
      if (!quiet && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 11)) @(posedge clock);
   endtask

   // Sends one request beat and updates the predictor when it is accepted.
   task automatic send_beat(logic [1:0] kind, logic [4:0] position, logic [15:0] sample);
      maybe_idle();
      start <= 1'b1;
      req_data <= '{kind: kind, position: position, sample: sample};
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 1'b0;
      if (kind == KIND_LOAD_A) samples_a[position] = sample;
      else if (kind == KIND_LOAD_B) samples_b[position] = sample;
      else if (kind == KIND_RUN) predict_warp_path();
      // Let start fall before the next beat is driven.
      @(posedge clock);
   endtask

   // Waits until the block has drained, then writes one configuration register.
   task automatic write_len(logic [1:0] index, logic [LEN_W-1:0] value);
      while (path_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CSR_LEN_A) pred_len_a = value;
      else if (index == CSR_LEN_B) pred_len_b = value;
   endtask

   // Loads the first count samples of both series with values from the given source.
   task automatic load_series(int mode, int count);
      logic [15:0] v;
      for (int p = 0; p < count; p++) begin
         v = mode == 0 ? 16'h7FFF : mode == 1 ? 16'h8000 : 16'($urandom);
         send_beat(KIND_LOAD_A, 5'(p), v);
         v = mode == 0 ? 16'h8000 : mode == 1 ? 16'h7FFF : 16'($urandom);
         send_beat(KIND_LOAD_B, 5'(p), v);
      end
   endtask

   // Extremes of samples and lengths, odd length values, ignored kinds and register indices.
   task automatic test_directed();
      load_series(0, MAXN);
      send_beat(KIND_RUN, '0, '0);
      write_len(CSR_LEN_A, 6'd32);
      write_len(CSR_LEN_B, 6'd32);
      send_beat(KIND_RUN, '0, '0);
      load_series(1, 4);
      write_len(CSR_LEN_A, 6'd0);
      send_beat(KIND_RUN, '0, '0);
      write_len(CSR_LEN_A, 6'd63);
      write_len(CSR_LEN_B, 6'd1);
      send_beat(KIND_RUN, '0, '0);
      write_len(CSR_UNUSED_2, 6'd5);
      write_len(CSR_UNUSED_3, 6'd9);
      send_beat(KIND_UNUSED, 5'd31, 16'hFFFF);
      write_len(CSR_LEN_A, 6'd2);
      write_len(CSR_LEN_B, 6'd40);
      send_beat(KIND_RUN, '0, '0);
   endtask

   // Random load sequences then runs, over random small and some large lengths.
   task automatic test_random_runs();
      int la, lb, loads;
      for (int r = 0; r < 6; r++) begin
         la = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 8);
         lb = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 8);
         if (r == 4) quiet = 1'b1;
         write_len(CSR_LEN_A, 6'(la));
         write_len(CSR_LEN_B, 6'(lb));
         loads = $urandom_range(2, 8);
         for (int k = 0; k < loads; k++) begin
            if ($urandom_range(0, 1)) send_beat(KIND_LOAD_A, 5'($urandom), 16'($urandom));
            else send_beat(KIND_LOAD_B, 5'($urandom), 16'($urandom));
         end
         if ($urandom_range(0, 3) == 0) send_beat(KIND_UNUSED, 5'($urandom), 16'($urandom));
         send_beat(KIND_RUN, 5'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      fail_count = 0;
      cycle_count = 0;
      quiet = 1'b0;
      pred_len_a = 6'd1;
      pred_len_b = 6'd1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      load_series(2, 8);
      test_random_runs();
      while (path_expected.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
